// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CHK_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CHK_NEVER(lbl, cond, msg) \
  `CHK_PROP(lbl, !(cond), msg)

`endif

// ===== rtl/dlms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlms_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dlms_pkg;

  localparam int DATA_W  = 16;
  localparam int MOM_W   = 24;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int RATE_W  = 16;
  localparam int WADDR_W = 2 * IDX_W;
  localparam int WDEPTH  = 1 << WADDR_W;
  localparam int VDEPTH  = 1 << IDX_W;

  // Request codes carried in the low bits of the input tuser.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_FWD  = 2'd1;
  localparam logic [1:0] REQ_BWD  = 2'd2;

  // Result kinds.
  localparam logic KIND_FWD = 1'b0;
  localparam logic KIND_BWD = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_IN_CNT  = 2'd0;
  localparam logic [1:0] REG_OUT_CNT = 2'd1;
  localparam logic [1:0] REG_LRATE   = 2'd2;
  localparam logic [1:0] REG_MGAIN   = 2'd3;

  typedef struct packed {
    logic               rd;
    logic               mac;
    logic               first;
    logic               op_bias;
    logic               op_grad;
    logic               upd_p1;
    logic               upd_p2;
    logic               upd_m;
    logic               upd_w;
    logic               emit;
    logic               emit_kind;
    logic               emit_last;
    logic [IDX_W-1:0]   emit_idx;
    logic               clr;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [WADDR_W-1:0] clr_addr;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/dlms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dlms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dlms_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlms_ctrl
// Sequencer for clearing, forward sums, backward sums and momentum updates.
// ----------------------------------------------------------------------------
module dlms_ctrl #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic                        last_i,
  input  logic [dlms_pkg::CNT_W-1:0]  in_cnt_i,
  input  logic [dlms_pkg::CNT_W-1:0]  out_cnt_i,
  input  dlms_pkg::stat_t             stat_i,
  output dlms_pkg::cmd_t              cmd_o
);

  typedef enum logic [11:0] {
    ST_CLR    = 12'b0000_0000_0001,
    ST_IDLE   = 12'b0000_0000_0010,
    ST_F_BIAS = 12'b0000_0000_0100,
    ST_F_RUN  = 12'b0000_0000_1000,
    ST_B_RUN  = 12'b0000_0001_0000,
    ST_DRAIN  = 12'b0000_0010_0000,
    ST_EMIT   = 12'b0000_0100_0000,
    ST_U_RD   = 12'b0000_1000_0000,
    ST_U_P1   = 12'b0001_0000_0000,
    ST_U_P2   = 12'b0010_0000_0000,
    ST_U_M    = 12'b0100_0000_0000,
    ST_U_W    = 12'b1000_0000_0000
  } state_e;

  localparam logic [dlms_pkg::CNT_W-1:0] MaxIn  = dlms_pkg::CNT_W'(MAX_INPUTS);
  localparam logic [dlms_pkg::CNT_W-1:0] MaxOut = dlms_pkg::CNT_W'(MAX_OUTPUTS);

  state_e                              state_q, state_d;
  logic [dlms_pkg::IDX_W-1:0]          r_q, r_d, c_q, c_d;
  logic                                mode_q, mode_d;
  logic                                ub_q, ub_d;
  logic                                dcnt_q, dcnt_d;
  logic [dlms_pkg::WADDR_W-1:0]        clr_q, clr_d;
  logic [dlms_pkg::CNT_W-1:0]          ni, no;
  logic                                c_last, r_last, accept;

  always_comb begin
    if (in_cnt_i == '0) begin
      ni = dlms_pkg::CNT_W'(1);
    end else if (in_cnt_i > MaxIn) begin
      ni = MaxIn;
    end else begin
      ni = in_cnt_i;
    end
    if (out_cnt_i == '0) begin
      no = dlms_pkg::CNT_W'(1);
    end else if (out_cnt_i > MaxOut) begin
      no = MaxOut;
    end else begin
      no = out_cnt_i;
    end
  end

  assign c_last     = ({1'b0, c_q} == ni - dlms_pkg::CNT_W'(1));
  assign r_last     = ({1'b0, r_q} == no - dlms_pkg::CNT_W'(1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    r_d     = r_q;
    c_d     = c_q;
    mode_d  = mode_q;
    ub_d    = ub_q;
    dcnt_d  = dcnt_q;
    clr_d   = clr_q;
    cmd_o          = '0;
    cmd_o.row      = r_q;
    cmd_o.col      = c_q;
    cmd_o.clr_addr = clr_q;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr = 1'b1;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && last_i) begin
          r_d = '0;
          c_d = '0;
          if (req_type_i == dlms_pkg::REQ_FWD) begin
            mode_d  = dlms_pkg::KIND_FWD;
            state_d = ST_F_BIAS;
          end else if (req_type_i == dlms_pkg::REQ_BWD) begin
            mode_d  = dlms_pkg::KIND_BWD;
            state_d = ST_B_RUN;
          end
        end
      end
      ST_F_BIAS: begin
        cmd_o.rd      = 1'b1;
        cmd_o.mac     = 1'b1;
        cmd_o.first   = 1'b1;
        cmd_o.op_bias = 1'b1;
        c_d           = '0;
        state_d       = ST_F_RUN;
      end
      ST_F_RUN: begin
        cmd_o.rd  = 1'b1;
        cmd_o.mac = 1'b1;
        if (c_last) begin
          state_d = ST_DRAIN;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_B_RUN: begin
        cmd_o.rd      = 1'b1;
        cmd_o.mac     = 1'b1;
        cmd_o.op_grad = 1'b1;
        cmd_o.first   = (r_q == '0);
        if (r_last) begin
          state_d = ST_DRAIN;
        end else begin
          r_d = r_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (dcnt_q) begin
          dcnt_d  = 1'b0;
          state_d = ST_EMIT;
        end else begin
          dcnt_d = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = mode_q;
          if (mode_q == dlms_pkg::KIND_FWD) begin
            cmd_o.emit_idx  = r_q;
            cmd_o.emit_last = r_last;
            if (r_last) begin
              state_d = ST_IDLE;
            end else begin
              r_d     = r_q + 1'b1;
              state_d = ST_F_BIAS;
            end
          end else begin
            cmd_o.emit_idx  = c_q;
            cmd_o.emit_last = c_last;
            r_d             = '0;
            if (c_last) begin
              c_d     = '0;
              ub_d    = 1'b0;
              state_d = ST_U_RD;
            end else begin
              c_d     = c_q + 1'b1;
              state_d = ST_B_RUN;
            end
          end
        end
      end
      ST_U_RD: begin
        cmd_o.rd      = 1'b1;
        cmd_o.op_bias = ub_q;
        state_d       = ST_U_P1;
      end
      ST_U_P1: begin
        cmd_o.upd_p1  = 1'b1;
        cmd_o.op_bias = ub_q;
        state_d       = ST_U_P2;
      end
      ST_U_P2: begin
        cmd_o.upd_p2  = 1'b1;
        cmd_o.op_bias = ub_q;
        state_d       = ST_U_M;
      end
      ST_U_M: begin
        cmd_o.upd_m   = 1'b1;
        cmd_o.op_bias = ub_q;
        state_d       = ST_U_W;
      end
      ST_U_W: begin
        cmd_o.upd_w   = 1'b1;
        cmd_o.op_bias = ub_q;
        state_d       = ST_U_RD;
        if (ub_q) begin
          ub_d = 1'b0;
          c_d  = '0;
          if (r_last) begin
            state_d = ST_IDLE;
          end else begin
            r_d = r_q + 1'b1;
          end
        end else if (c_last) begin
          ub_d = 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      r_q     <= '0;
      c_q     <= '0;
      mode_q  <= dlms_pkg::KIND_FWD;
      ub_q    <= 1'b0;
      dcnt_q  <= 1'b0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      mode_q  <= mode_d;
      ub_q    <= ub_d;
      dcnt_q  <= dcnt_d;
      clr_q   <= clr_d;
    end
  end

endmodule

// ===== rtl/dlms_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlms_dpath
// Parameter stores, latches, MAC pipeline, momentum update and result register.
// ----------------------------------------------------------------------------
module dlms_dpath #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dlms_pkg::cmd_t                    cmd_i,
  output dlms_pkg::stat_t                   stat_o,
  input  logic                              in_acc_i,
  input  logic [1:0]                        req_type_i,
  input  logic [dlms_pkg::IDX_W-1:0]        row_i,
  input  logic [dlms_pkg::IDX_W-1:0]        col_i,
  input  logic                              is_bias_i,
  input  logic signed [dlms_pkg::DATA_W-1:0] data_i,
  input  logic [dlms_pkg::RATE_W-1:0]       lrate_i,
  input  logic [dlms_pkg::RATE_W-1:0]       mgain_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_kind_o,
  output logic [dlms_pkg::IDX_W-1:0]        out_idx_o,
  output logic [dlms_pkg::DATA_W-1:0]       out_val_o,
  output logic                              out_last_o
);

  localparam logic [dlms_pkg::CNT_W-1:0] MaxIn  = dlms_pkg::CNT_W'(MAX_INPUTS);
  localparam logic [dlms_pkg::CNT_W-1:0] MaxOut = dlms_pkg::CNT_W'(MAX_OUTPUTS);

  function automatic logic [15:0] sat16(input logic signed [29:0] v);
    if (v > 30'sd32767) begin
      return 16'h7FFF;
    end else if (v < -30'sd32768) begin
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic logic [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) begin
      return 24'h7FFFFF;
    end else if (v < -30'sd8388608) begin
      return 24'h800000;
    end
    return v[23:0];
  endfunction

  logic row_in_out, row_in_in, col_in_in, ld;
  logic [15:0] w_rd, b_rd, x_rd, g_rd, w_new;
  logic [23:0] wm_rd, bm_rd;
  logic        w_we, b_we, x_we, g_we, wm_we, bm_we;

  assign row_in_out = ({1'b0, row_i} < MaxOut);
  assign row_in_in  = ({1'b0, row_i} < MaxIn);
  assign col_in_in  = ({1'b0, col_i} < MaxIn);
  assign ld         = in_acc_i && (req_type_i == dlms_pkg::REQ_LOAD);

  assign w_we  = (ld && !is_bias_i && row_in_out && col_in_in) ||
                 (cmd_i.upd_w && !cmd_i.op_bias);
  assign b_we  = (ld && is_bias_i && row_in_out) || (cmd_i.upd_w && cmd_i.op_bias);
  assign x_we  = in_acc_i && (req_type_i == dlms_pkg::REQ_FWD) && row_in_in;
  assign g_we  = in_acc_i && (req_type_i == dlms_pkg::REQ_BWD) && row_in_out;
  assign wm_we = cmd_i.clr || (cmd_i.upd_w && !cmd_i.op_bias);
  assign bm_we = cmd_i.clr || (cmd_i.upd_w && cmd_i.op_bias);

  logic [23:0] m_new_q;

  dlms_ram #(.WIDTH(16), .DEPTH(dlms_pkg::WDEPTH)) u_wram (
    .clk_i, .we_i(w_we),
    .waddr_i(ld ? {row_i, col_i} : {cmd_i.row, cmd_i.col}),
    .wdata_i(ld ? data_i : w_new),
    .re_i(cmd_i.rd), .raddr_i({cmd_i.row, cmd_i.col}), .rdata_o(w_rd)
  );

  dlms_ram #(.WIDTH(16), .DEPTH(dlms_pkg::VDEPTH)) u_bram (
    .clk_i, .we_i(b_we),
    .waddr_i(ld ? row_i : cmd_i.row),
    .wdata_i(ld ? data_i : w_new),
    .re_i(cmd_i.rd), .raddr_i(cmd_i.row), .rdata_o(b_rd)
  );

  dlms_ram #(.WIDTH(16), .DEPTH(dlms_pkg::VDEPTH)) u_xram (
    .clk_i, .we_i(x_we), .waddr_i(row_i), .wdata_i(data_i),
    .re_i(cmd_i.rd), .raddr_i(cmd_i.col), .rdata_o(x_rd)
  );

  dlms_ram #(.WIDTH(16), .DEPTH(dlms_pkg::VDEPTH)) u_gram (
    .clk_i, .we_i(g_we), .waddr_i(row_i), .wdata_i(data_i),
    .re_i(cmd_i.rd), .raddr_i(cmd_i.row), .rdata_o(g_rd)
  );

  dlms_ram #(.WIDTH(24), .DEPTH(dlms_pkg::WDEPTH)) u_wmram (
    .clk_i, .we_i(wm_we),
    .waddr_i(cmd_i.clr ? cmd_i.clr_addr : {cmd_i.row, cmd_i.col}),
    .wdata_i(cmd_i.clr ? 24'd0 : m_new_q),
    .re_i(cmd_i.rd), .raddr_i({cmd_i.row, cmd_i.col}), .rdata_o(wm_rd)
  );

  dlms_ram #(.WIDTH(24), .DEPTH(dlms_pkg::VDEPTH)) u_bmram (
    .clk_i, .we_i(bm_we),
    .waddr_i(cmd_i.clr ? cmd_i.clr_addr[dlms_pkg::IDX_W-1:0] : cmd_i.row),
    .wdata_i(cmd_i.clr ? 24'd0 : m_new_q),
    .re_i(cmd_i.rd), .raddr_i(cmd_i.row), .rdata_o(bm_rd)
  );

  // MAC pipeline: read, multiply, accumulate.
  logic s1_mac_q, s1_first_q, s1_bias_q, s1_grad_q;
  logic s2_mac_q, s2_first_q;
  logic signed [31:0] prod_d, prod_q;
  logic signed [39:0] acc_q, acc_rnd;
  logic signed [15:0] op_b;

  assign op_b = s1_grad_q ? $signed(g_rd) : $signed(x_rd);

  always_comb begin
    if (s1_bias_q) begin
      prod_d = $signed({{4{b_rd[15]}}, b_rd, 12'b0});
    end else begin
      prod_d = $signed(w_rd) * op_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_mac_q <= 1'b0;
      s2_mac_q <= 1'b0;
    end else begin
      s1_mac_q <= cmd_i.mac;
      s2_mac_q <= s1_mac_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_first_q <= cmd_i.first;
    s1_bias_q  <= cmd_i.op_bias;
    s1_grad_q  <= cmd_i.op_grad;
    s2_first_q <= s1_first_q;
    prod_q     <= prod_d;
    if (s2_mac_q) begin
      acc_q <= s2_first_q ? 40'(prod_q) : acc_q + 40'(prod_q);
    end
  end

  assign acc_rnd = acc_q + 40'sd2048;

  // Momentum update, one step per cycle.
  logic signed [31:0] p1_q;
  logic signed [48:0] t1_q;
  logic signed [40:0] t2_q;
  logic signed [49:0] msum;
  logic signed [23:0] m_old;
  logic signed [15:0] param;
  logic signed [25:0] wv;

  assign m_old = cmd_i.op_bias ? $signed(bm_rd) : $signed(wm_rd);
  assign param = cmd_i.op_bias ? $signed(b_rd) : $signed(w_rd);
  assign msum  = 50'(t1_q) + (50'(t2_q) <<< 4) + 50'sd524288;
  assign wv    = $signed({{2{param[15]}}, param, 8'b0}) -
                 $signed({{2{m_new_q[23]}}, m_new_q}) + 26'sd128;
  assign w_new = sat16(30'($signed(wv[25:8])));

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_p1) begin
      p1_q <= cmd_i.op_bias ? $signed({{4{g_rd[15]}}, g_rd, 12'b0})
                            : $signed(g_rd) * $signed(x_rd);
    end
    if (cmd_i.upd_p2) begin
      t1_q <= $signed({1'b0, lrate_i}) * p1_q;
      t2_q <= $signed({1'b0, mgain_i}) * m_old;
    end
    if (cmd_i.upd_m) begin
      m_new_q <= sat24($signed(msum[49:20]));
    end
  end

  // Result register.
  logic out_valid_q, out_kind_q, out_last_q;
  logic [dlms_pkg::IDX_W-1:0]  out_idx_q;
  logic [dlms_pkg::DATA_W-1:0] out_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.emit_kind;
      out_idx_q  <= cmd_i.emit_idx;
      out_last_q <= cmd_i.emit_last;
      out_val_q  <= sat16(30'($signed(acc_rnd[39:12])));
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign out_idx_o       = out_idx_q;
  assign out_val_o       = out_val_q;
  assign out_last_o      = out_last_q;

endmodule

// ===== rtl/dense_layer_momentum_sgd_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_momentum_sgd_unit
// Fully connected layer in Q4.12 with forward pass, backward pass and
// momentum SGD update of weights and biases.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  s_axis    in         load, forward element or backward gradient item
//  m_axis    out        forward output or input gradient item
//  APB       in/out     input_count, output_count, learn_rate, momentum_gain
//
// Loads and elements without the last mark leave the unit ready for the
// next item. A forward vector is summed output by output: a bias step,
// then one MAC per cycle over the inputs, and the result is emitted before
// the next sum starts. A backward vector sums the gradients input by input,
// then runs the update, which shares one read port per store and one step
// per cycle. After reset the momentum stores are cleared; items are not
// taken then. A stalled result holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module dense_layer_momentum_sgd_unit #(
  parameter int MAX_INPUTS  = 64,
  parameter int MAX_OUTPUTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // row_index[5:0], col_index[11:6], data_value[27:12]
  input  logic [2:0]  s_axis_tuser,   // req_type[1:0], is_bias[2]
  input  logic        s_axis_tlast,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // result_index[5:0], result_value[21:6]
  output logic [0:0]  m_axis_tuser,   // result_kind[0]
  output logic        m_axis_tlast,
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers, written in the APB access phase.
  logic [dlms_pkg::CNT_W-1:0]  in_cnt_q, out_cnt_q;
  logic [dlms_pkg::RATE_W-1:0] lrate_q, mgain_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= dlms_pkg::CNT_W'(64);
      out_cnt_q <= dlms_pkg::CNT_W'(64);
      lrate_q   <= dlms_pkg::RATE_W'(655);
      mgain_q   <= dlms_pkg::RATE_W'(58982);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        dlms_pkg::REG_IN_CNT:  in_cnt_q  <= pwdata[dlms_pkg::CNT_W-1:0];
        dlms_pkg::REG_OUT_CNT: out_cnt_q <= pwdata[dlms_pkg::CNT_W-1:0];
        dlms_pkg::REG_LRATE:   lrate_q   <= pwdata[dlms_pkg::RATE_W-1:0];
        dlms_pkg::REG_MGAIN:   mgain_q   <= pwdata[dlms_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      dlms_pkg::REG_IN_CNT:  prdata = 32'(in_cnt_q);
      dlms_pkg::REG_OUT_CNT: prdata = 32'(out_cnt_q);
      dlms_pkg::REG_LRATE:   prdata = 32'(lrate_q);
      dlms_pkg::REG_MGAIN:   prdata = 32'(mgain_q);
      default:               prdata = '0;
    endcase
  end

  dlms_pkg::cmd_t  cmd;
  dlms_pkg::stat_t stat;
  logic            in_acc;

  // The sequencer takes items only while it has nothing else to do.
  assign in_acc = s_axis_tvalid && s_axis_tready;

  dlms_ctrl #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .req_type_i(s_axis_tuser[1:0]),
    .last_i(s_axis_tlast),
    .in_cnt_i(in_cnt_q),
    .out_cnt_i(out_cnt_q),
    .stat_i(stat),
    .cmd_o(cmd)
  );

  dlms_dpath #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_dpath (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .in_acc_i(in_acc),
    .req_type_i(s_axis_tuser[1:0]),
    .row_i(s_axis_tdata[5:0]),
    .col_i(s_axis_tdata[11:6]),
    .is_bias_i(s_axis_tuser[2]),
    .data_i($signed(s_axis_tdata[27:12])),
    .lrate_i(lrate_q),
    .mgain_i(mgain_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_kind_o(m_axis_tuser[0]),
    .out_idx_o(m_axis_tdata[5:0]),
    .out_val_o(m_axis_tdata[21:6]),
    .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata[23:22] = 2'b00;

endmodule

// ===== rtl/dlms_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlms_chk
// Port-level checks on the layer unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlms_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic        in_acc;
  logic        in_load;
  logic        out_stall;
  logic        vec_end;
  logic [25:0] out_item;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_load   = in_acc && (s_axis_tuser[1:0] == dlms_pkg::REQ_LOAD);
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign vec_end   = in_acc && s_axis_tlast &&
                     (s_axis_tuser[1:0] == dlms_pkg::REQ_FWD ||
                      s_axis_tuser[1:0] == dlms_pkg::REQ_BWD);
  assign out_item  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  `CHK_PROP(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_item), "result changed while stalled")
  `CHK_PROP(a_load_ready, in_load |=> s_axis_tready, "load item left the unit busy")
  `CHK_PROP(a_vec_busy, vec_end |=> !s_axis_tready, "vector end did not start a pass")
  `CHK_NEVER(a_emit_idle, $rose(m_axis_tvalid) && $past(s_axis_tready), "result without a pass")

endmodule

bind dense_layer_momentum_sgd_unit dlms_chk u_dlms_chk (.*);

// ===== tb/tb_dense_layer_momentum_sgd_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_layer_momentum_sgd_unit
// Self-checking bench for the fully connected layer. A scoreboard holds its
// own copy of weights, biases, momentum and latches and works out the forward
// outputs, input gradients and momentum updates for every accepted item.
// Results are compared field by field in order, under random idling on both
// sides and over several layer sizes and learning settings.
// ----------------------------------------------------------------------------
module tb_dense_layer_momentum_sgd_unit;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_NONE = 2'd3;
  // Cycles without any handshake on either side before the run is abandoned.
  localparam int STALL_LIMIT = 20000;
  // Cycles the bench waits after reset while the block clears its momentum stores.
  localparam int CLEAR_CYCLES = 4200;

  typedef struct {
    logic [1:0]         req;
    logic [5:0]         row;
    logic [5:0]         col;
    logic               bias;
    logic signed [15:0] val;
    logic               last;
  } layer_req_t;

  typedef struct {
    logic               kind;
    logic [5:0]         idx;
    logic signed [15:0] val;
    logic               last;
  } layer_res_t;

  // Scoreboard: mirrors the layer state and keeps the results still owed.
  class layer_scoreboard;
    logic signed [15:0] weight [64][64];
    logic signed [15:0] bias [64];
    logic signed [23:0] weight_mom [64][64];
    logic signed [23:0] bias_mom [64];
    logic signed [15:0] in_latch [64];
    logic signed [15:0] grad_latch [64];
    logic [6:0]  in_cnt;
    logic [6:0]  out_cnt;
    longint      lrate;
    longint      mgain;
    layer_res_t  owed [$];
    int          errors;
    int          checked;

    function new();
      for (int r = 0; r < 64; r++) begin
        for (int c = 0; c < 64; c++) begin
          weight[r][c] = '0;
          weight_mom[r][c] = '0;
        end
        bias[r] = '0;
        bias_mom[r] = '0;
        in_latch[r] = '0;
        grad_latch[r] = '0;
      end
      in_cnt = 7'd64;
      out_cnt = 7'd64;
      lrate = 655;
      mgain = 58982;
      errors = 0;
      checked = 0;
    endfunction

    function int n_in();
      return (in_cnt < 1) ? 1 : (in_cnt > 64) ? 64 : int'(in_cnt);
    endfunction

    function int n_out();
      return (out_cnt < 1) ? 1 : (out_cnt > 64) ? 64 : int'(out_cnt);
    endfunction

    // Round half up at the dropped fraction, then saturate to the width.
    function longint round_sat(longint v, int drop, int bits);
      longint hi;
      longint lo;
      longint s;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      s = (v + (longint'(1) <<< (drop - 1))) >>> drop;
      return (s > hi) ? hi : (s < lo) ? lo : s;
    endfunction

    function longint next_mom(longint grad_q40, longint old_mom);
      return round_sat(lrate * grad_q40 + mgain * old_mom * 16, 20, 24);
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        dlms_pkg::REG_IN_CNT:  in_cnt = value[6:0];
        dlms_pkg::REG_OUT_CNT: out_cnt = value[6:0];
        dlms_pkg::REG_LRATE:   lrate = longint'(value[15:0]);
        dlms_pkg::REG_MGAIN:   mgain = longint'(value[15:0]);
        default: ;
      endcase
    endfunction

    function void owe(logic kind, int idx, longint val, logic last);
      layer_res_t res;
      res.kind = kind;
      res.idx = idx[5:0];
      res.val = val[15:0];
      res.last = last;
      owed.push_back(res);
    endfunction

    function void note_item(layer_req_t it);
      int ni;
      int no;
      longint acc;
      longint m;
      ni = n_in();
      no = n_out();
      case (it.req)
        dlms_pkg::REQ_LOAD: begin
          if (it.bias) bias[it.row] = it.val;
          else weight[it.row][it.col] = it.val;
        end
        dlms_pkg::REQ_FWD: begin
          in_latch[it.row] = it.val;
          if (it.last) begin
            for (int r = 0; r < no; r++) begin
              acc = longint'(bias[r]) * 4096;
              for (int c = 0; c < ni; c++)
                acc += longint'(weight[r][c]) * longint'(in_latch[c]);
              owe(dlms_pkg::KIND_FWD, r, round_sat(acc, 12, 16), r == no - 1);
            end
          end
        end
        dlms_pkg::REQ_BWD: begin
          grad_latch[it.row] = it.val;
          if (it.last) begin
            // Input gradients use the weights as they stand before the update.
            for (int c = 0; c < ni; c++) begin
              acc = 0;
              for (int r = 0; r < no; r++)
                acc += longint'(weight[r][c]) * longint'(grad_latch[r]);
              owe(dlms_pkg::KIND_BWD, c, round_sat(acc, 12, 16), c == ni - 1);
            end
            for (int r = 0; r < no; r++) begin
              for (int c = 0; c < ni; c++) begin
                m = next_mom(longint'(grad_latch[r]) * longint'(in_latch[c]),
                             longint'(weight_mom[r][c]));
                weight_mom[r][c] = m[23:0];
                weight[r][c] = 16'(round_sat(longint'(weight[r][c]) * 256 - m, 8, 16));
              end
              m = next_mom(longint'(grad_latch[r]) * 4096, longint'(bias_mom[r]));
              bias_mom[r] = m[23:0];
              bias[r] = 16'(round_sat(longint'(bias[r]) * 256 - m, 8, 16));
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(layer_res_t got);
      layer_res_t want;
      checked++;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result kind=%0d idx=%0d val=%0d",
                         got.kind, got.idx, got.val));
      end else begin
        want = owed.pop_front();
        if (got.kind !== want.kind || got.idx !== want.idx ||
            got.val !== want.val || got.last !== want.last)
          report($sformatf("kind %0d/%0d idx %0d/%0d val %0d/%0d last %0d/%0d",
                           got.kind, want.kind, got.idx, want.idx,
                           got.val, want.val, got.last, want.last));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  layer_scoreboard sb = new();

  // Which store entries hold a written value; reads of others are avoided.
  bit w_ok [64][64];
  bit b_ok [64];
  bit x_ok [64];
  bit g_ok [64];
  bit quiet;
  int items_sent;
  int idle_cycles;
  int phases_run;

  dense_layer_momentum_sgd_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Result side: check every accepted item, then decide the next ready with
  // random stall bursts, except in the final quiet phase.
  initial begin
    int stall_left;
    layer_res_t got;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got.idx = m_axis_tdata[5:0];
        got.val = m_axis_tdata[21:6];
        got.kind = m_axis_tuser[0];
        got.last = m_axis_tlast;
        sb.check_result(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a long stretch without any handshake means the block hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // A single register write: setup phase, then the access phase.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic write_layer(int ni, int no, int lr, int mf);
    write_reg(dlms_pkg::REG_IN_CNT, ni);
    write_reg(dlms_pkg::REG_OUT_CNT, no);
    write_reg(dlms_pkg::REG_LRATE, lr);
    write_reg(dlms_pkg::REG_MGAIN, mf);
  endtask

  // Offer one item, with an optional random gap first, and wait for it.
  task automatic send(layer_req_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, it.val, it.col, it.row};
    s_axis_tuser <= {it.bias, it.req};
    s_axis_tlast <= it.last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(it);
    items_sent++;
    case (it.req)
      dlms_pkg::REQ_LOAD: if (it.bias) b_ok[it.row] = 1'b1; else w_ok[it.row][it.col] = 1'b1;
      dlms_pkg::REQ_FWD:  x_ok[it.row] = 1'b1;
      dlms_pkg::REQ_BWD:  g_ok[it.row] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic send_fields(logic [1:0] req, int row, int col, logic bias,
                             logic [15:0] val, logic last);
    layer_req_t it;
    it.req = req;
    it.row = row[5:0];
    it.col = col[5:0];
    it.bias = bias;
    it.val = val;
    it.last = last;
    send(it);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Sender stops, every owed result arrives, and then the block is given
  // the time its trailing weight update may still need.
  task automatic drain();
    int settle;
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    settle = 5 * sb.n_out() * (sb.n_in() + 1) + sb.n_in() * (sb.n_out() + 3) + 20;
    repeat (settle) @(posedge clk_i);
  endtask

  // Write every entry the current layer size reads but that holds nothing yet.
  task automatic fill_gaps();
    for (int r = 0; r < sb.n_out(); r++) begin
      for (int c = 0; c < sb.n_in(); c++)
        if (!w_ok[r][c]) send_fields(dlms_pkg::REQ_LOAD, r, c, 1'b0, pick_value(), 1'b0);
      if (!b_ok[r])
        send_fields(dlms_pkg::REQ_LOAD, r, $urandom_range(0, 63), 1'b1, pick_value(), 1'b0);
      if (!g_ok[r]) send_fields(dlms_pkg::REQ_BWD, r, $urandom, 1'b0, pick_value(), 1'b0);
    end
    for (int c = 0; c < sb.n_in(); c++)
      if (!x_ok[c]) send_fields(dlms_pkg::REQ_FWD, c, $urandom, 1'b0, pick_value(), 1'b0);
  endtask

  // A forward or backward vector: a random subset of elements in order, the
  // final one marked last. Skipped elements keep their latched values.
  task automatic send_vector(logic [1:0] req, int len);
    int picks [$];
    for (int i = 0; i < len; i++)
      if ($urandom_range(0, 3) != 0) picks.push_back(i);
    if ($urandom_range(0, 7) == 0) picks.push_back($urandom_range(len - 1, 63));
    if (picks.size() == 0) picks.push_back($urandom_range(0, len - 1));
    foreach (picks[k])
      send_fields(req, picks[k], $urandom, 1'($urandom), pick_value(),
                  k == picks.size() - 1);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25)
      send_vector(dlms_pkg::REQ_FWD, sb.n_in());
    else if (pick < 45)
      send_vector(dlms_pkg::REQ_BWD, sb.n_out());
    else if (pick < 80)
      send_fields(dlms_pkg::REQ_LOAD,
                  $urandom_range(0, 3) != 0 ? $urandom_range(0, sb.n_out() - 1)
                                            : $urandom_range(0, 63),
                  $urandom_range(0, 63), 1'($urandom), pick_value(), 1'($urandom));
    else if (pick < 90)
      send_fields(REQ_NONE, $urandom, $urandom, 1'($urandom), pick_value(), 1'($urandom));
    else
      send_fields($urandom_range(0, 1) ? dlms_pkg::REQ_FWD : dlms_pkg::REQ_BWD,
                  $urandom_range(0, 63), $urandom, 1'($urandom), pick_value(), 1'b0);
  endtask

  initial begin
    int cfg [6][4];
    int phase_start;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    s_axis_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    quiet = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    phases_run = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The momentum stores are cleared before any item is taken.
    repeat (CLEAR_CYCLES) @(posedge clk_i);

    // Directed part: a 2x2 layer at full learning rate and momentum gain,
    // with the largest and smallest values so that every sum saturates.
    write_layer(2, 2, 65535, 65535);
    send_fields(dlms_pkg::REQ_LOAD, 0, 0, 1'b0, 16'h7fff, 1'b0);
    send_fields(dlms_pkg::REQ_LOAD, 0, 1, 1'b0, 16'h8000, 1'b1);
    send_fields(dlms_pkg::REQ_LOAD, 1, 0, 1'b0, 16'h8000, 1'b0);
    send_fields(dlms_pkg::REQ_LOAD, 1, 1, 1'b0, 16'h7fff, 1'b0);
    send_fields(dlms_pkg::REQ_LOAD, 0, 63, 1'b1, 16'h7fff, 1'b0);
    send_fields(dlms_pkg::REQ_LOAD, 1, 0, 1'b1, 16'h8000, 1'b0);
    send_fields(dlms_pkg::REQ_LOAD, 63, 63, 1'b0, 16'h1234, 1'b0);
    send_fields(REQ_NONE, 63, 63, 1'b1, 16'hffff, 1'b1);
    send_fields(dlms_pkg::REQ_FWD, 0, 63, 1'b1, 16'h8000, 1'b0);
    send_fields(dlms_pkg::REQ_FWD, 1, 0, 1'b0, 16'h7fff, 1'b1);
    send_fields(dlms_pkg::REQ_BWD, 0, 63, 1'b1, 16'h7fff, 1'b0);
    send_fields(dlms_pkg::REQ_BWD, 1, 0, 1'b0, 16'h8000, 1'b1);
    // Backward before a new forward, with one gradient element missing.
    send_fields(dlms_pkg::REQ_BWD, 1, 0, 1'b0, 16'h0400, 1'b1);
    // The trigger may come on an element beyond the layer size.
    send_fields(dlms_pkg::REQ_FWD, 63, 0, 1'b0, 16'h0001, 1'b1);
    send_fields(dlms_pkg::REQ_BWD, 63, 0, 1'b0, 16'hffff, 1'b1);
    drain();

    // Layer sizes and learning settings per phase; counts of 0 and of 127
    // exercise the clamping, the last phase runs without any idling.
    cfg = '{'{3, 4, 655, 58982}, '{127, 0, 65535, 0}, '{0, 6, 0, 65535},
            '{8, 8, $urandom_range(0, 65535), $urandom_range(0, 65535)},
            '{5, 3, $urandom_range(0, 65535), $urandom_range(0, 65535)},
            '{4, 4, $urandom_range(0, 65535), $urandom_range(0, 65535)}};
    foreach (cfg[p]) begin
      quiet = (p == 5);
      write_layer(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3]);
      fill_gaps();
      phase_start = items_sent;
      while (items_sent - phase_start < 12) random_item();
      drain();
      phases_run++;
    end

    $display("tb: %0d items sent over %0d layer settings, %0d results checked",
             items_sent, phases_run + 1, sb.checked);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed.size()));
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
